// ===== rtl/pic_pkg.sv =====
`default_nettype none

package pic_pkg;

   localparam int SRC_ID_W = 5;

   localparam logic [7:0] SPURIOUS_VECTOR = 8'd24;
   localparam logic [7:0] AUTOVECTOR_BASE = 8'd25;

   localparam logic [7:0] OFS_MASK = 8'h22;
   localparam logic [7:0] OFS_PEND = 8'h26;
   localparam logic [7:0] LAST_CTRL_OFS = 8'd12;
   localparam logic [7:0] AUTO_FLAG = 8'h80;
   localparam logic [2:0] CPU_LEVEL_MAX = 3'h7;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_READ   = 3'd1,
      ACT_WRITE  = 3'd2,
      ACT_ASSERT = 3'd3,
      ACT_CLEAR  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic                en;
      logic [2:0]          level;
      logic [1:0]          prio;
      logic                auto_vec;
      logic [7:0]          vector;
      logic [SRC_ID_W-1:0] src;
   } scan_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [2:0]          level;
      logic [1:0]          prio;
      logic [7:0]          vector;
      logic [SRC_ID_W-1:0] src;
   } scan_best_type;

   function automatic logic [7:0] ctrl_reset_value(input int unsigned idx);
      logic [7:0] value;
      value = 8'h00;
      if (idx >= 1 && idx <= 7) begin
         value = 8'(4 * idx);
      end else if (idx == 8) begin
         value = 8'd32;
      end else if (idx >= 9 && idx <= 11) begin
         value = AUTO_FLAG;
      end
      return value;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pic_scan.sv =====
`default_nettype none

module pic_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pic_pkg::scan_cmd_type cmd,
   output pic_pkg::scan_best_type     best
);

   pic_pkg::scan_best_type best_ff;
   pic_pkg::scan_best_type best_in;
   logic better;
   logic [7:0] cand_vector;

   always_comb begin
      better = (cmd.level > best_ff.level) ||
               ((cmd.level == best_ff.level) && (cmd.prio > best_ff.prio));
      cand_vector = cmd.auto_vec ?
                    (pic_pkg::AUTOVECTOR_BASE - 8'd1 + {5'd0, cmd.level}) : cmd.vector;
      best_in = best_ff;
      if (cmd.start) begin
         best_in = '0;
      end else if (cmd.en && better) begin
         best_in.valid = 1'b1;
         best_in.level = cmd.level;
         best_in.prio = cmd.prio;
         best_in.vector = cand_vector;
         best_in.src = cmd.src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

endmodule

`default_nettype wire

// ===== rtl/prioritized_interrupt_controller_core.sv =====
// Level and priority interrupt controller for up to NUM_SOURCES sources.
// Requests arrive on the req_ channel: a tick with the CPU level, a register
// read or write, a source assert with its vector, or a source clear. Each
// request produces exactly one response on the rsp_ channel.
// A tick scans the sources one per cycle through a single shared compare unit,
// then passes through the commit state to the output register. Reads, writes,
// asserts and clears go from acceptance straight to the commit state. The block
// holds one request at a time: req_stall is high from acceptance until the
// response is loaded into the output register, so a new request can be taken
// while the previous response still waits there.
// When the receiver holds rsp_stall, the response stays on the ports and a
// finished request waits in the commit state until the output register frees.
// Synchronous reset clears all pending bits, masks every source, restores the
// default control bytes and sets every stored vector to the spurious vector.
`default_nettype none

module prioritized_interrupt_controller_core #(
   parameter int NUM_SOURCES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_reg_offset,
   input  wire logic [31:0] req_write_data,
   input  wire logic [4:0]  req_source_id,
   input  wire logic [7:0]  req_source_vector,
   input  wire logic [2:0]  req_cpu_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_take_interrupt,
   output logic [7:0]       rsp_taken_vector,
   output logic [2:0]       rsp_new_level,
   output logic [4:0]       rsp_taken_source,
   output logic             rsp_bad_access
);

   localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic [SRC_W-1:0] LAST_IDX = SRC_W'(NUM_SOURCES - 1);

   pic_pkg::state_type state_ff, state_in;
   logic [SRC_W-1:0] scan_idx_ff, scan_idx_in;

   logic [2:0]  act_ff;
   logic [7:0]  ofs_ff;
   logic [31:0] data_ff;
   logic [4:0]  src_ff;
   logic [7:0]  vec_ff;
   logic [2:0]  cpu_ff;

   logic [31:0] pending_ff, pending_in;
   logic [31:0] mask_ff, mask_in;
   logic [7:0]  ctrl_ff [NUM_SOURCES];
   logic [7:0]  svec_ff [NUM_SOURCES];

   logic             ctrl_we;
   logic             svec_we;
   logic [7:0]       svec_wdata;
   logic [SRC_W-1:0] ctrl_addr;
   logic [SRC_W-1:0] rd_idx;
   logic [7:0]       ctrl_rd;
   logic             ctrl_hit;
   logic             src_ok;
   logic             accept;
   logic             out_free;
   logic             commit;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_take_ff, rsp_take_in;
   logic [7:0]  rsp_vector_ff, rsp_vector_in;
   logic [2:0]  rsp_level_ff, rsp_level_in;
   logic [4:0]  rsp_source_ff, rsp_source_in;
   logic        rsp_bad_ff, rsp_bad_in;

   pic_pkg::scan_cmd_type  scan_cmd;
   pic_pkg::scan_best_type best;

   pic_scan u_scan (
      .clock(clock),
      .reset(reset),
      .cmd  (scan_cmd),
      .best (best)
   );

   assign req_stall = (state_ff != pic_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit = (state_ff == pic_pkg::ST_COMMIT) && out_free;

   assign ctrl_hit = (ofs_ff <= pic_pkg::LAST_CTRL_OFS) &&
                     (({1'b0, ofs_ff} + 9'd1) < 9'(NUM_SOURCES));
   assign ctrl_addr = SRC_W'(ofs_ff + 8'd1);
   assign src_ok = ({1'b0, src_ff} < 6'(NUM_SOURCES));
   assign rd_idx = (state_ff == pic_pkg::ST_SCAN) ? scan_idx_ff : ctrl_addr;
   assign ctrl_rd = ctrl_ff[rd_idx];

   always_comb begin
      scan_cmd.start = accept && (req_action == pic_pkg::ACT_TICK);
      scan_cmd.en = (state_ff == pic_pkg::ST_SCAN) &&
                    pending_ff[5'(scan_idx_ff)] && !mask_ff[5'(scan_idx_ff)];
      scan_cmd.level = ctrl_rd[4:2];
      scan_cmd.prio = ctrl_rd[1:0];
      scan_cmd.auto_vec = ctrl_rd[7];
      scan_cmd.vector = svec_ff[scan_idx_ff];
      scan_cmd.src = 5'(scan_idx_ff);
   end

   always_comb begin
      state_in = state_ff;
      scan_idx_in = scan_idx_ff;
      unique case (state_ff)
         pic_pkg::ST_IDLE: begin
            if (accept) begin
               scan_idx_in = '0;
               state_in = (req_action == pic_pkg::ACT_TICK) ?
                          pic_pkg::ST_SCAN : pic_pkg::ST_COMMIT;
            end
         end
         pic_pkg::ST_SCAN: begin
            scan_idx_in = scan_idx_ff + SRC_W'(1);
            if (scan_idx_ff == LAST_IDX) begin
               state_in = pic_pkg::ST_COMMIT;
            end
         end
         pic_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = pic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pic_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pending_in = pending_ff;
      mask_in = mask_ff;
      ctrl_we = 1'b0;
      svec_we = 1'b0;
      svec_wdata = vec_ff;
      rsp_read_data_in = '0;
      rsp_take_in = 1'b0;
      rsp_vector_in = '0;
      rsp_level_in = '0;
      rsp_source_in = '0;
      rsp_bad_in = 1'b0;
      if (commit) begin
         unique case (act_ff)
            pic_pkg::ACT_TICK: begin
               if (best.valid && (best.level > cpu_ff)) begin
                  pending_in[best.src] = 1'b0;
                  rsp_take_in = 1'b1;
                  rsp_vector_in = best.vector;
                  rsp_level_in = best.level;
                  rsp_source_in = best.src;
               end
            end
            pic_pkg::ACT_READ: begin
               priority if (ofs_ff == pic_pkg::OFS_MASK) begin
                  rsp_read_data_in = mask_ff;
               end else if (ofs_ff == pic_pkg::OFS_PEND) begin
                  rsp_read_data_in = pending_ff;
               end else if (ctrl_hit) begin
                  rsp_read_data_in = {24'd0, ctrl_rd};
               end else begin
                  rsp_bad_in = 1'b1;
               end
            end
            pic_pkg::ACT_WRITE: begin
               priority if (ofs_ff == pic_pkg::OFS_MASK) begin
                  mask_in = data_ff;
               end else if (ofs_ff == pic_pkg::OFS_PEND) begin
                  mask_in = mask_ff;
               end else if (ctrl_hit) begin
                  ctrl_we = 1'b1;
               end else begin
                  rsp_bad_in = 1'b1;
               end
            end
            pic_pkg::ACT_ASSERT: begin
               if (src_ok && !pending_ff[src_ff]) begin
                  pending_in[src_ff] = 1'b1;
                  svec_we = !mask_ff[src_ff];
               end
            end
            pic_pkg::ACT_CLEAR: begin
               if (src_ok && pending_ff[src_ff]) begin
                  pending_in[src_ff] = 1'b0;
                  svec_we = 1'b1;
                  svec_wdata = pic_pkg::SPURIOUS_VECTOR;
               end
            end
            default: begin
               rsp_bad_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pic_pkg::ST_IDLE;
         scan_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pending_ff <= '0;
         mask_ff <= '1;
      end else begin
         state_ff <= state_in;
         scan_idx_ff <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff <= pending_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            ctrl_ff[i] <= pic_pkg::ctrl_reset_value(i);
            svec_ff[i] <= pic_pkg::SPURIOUS_VECTOR;
         end
      end else begin
         if (ctrl_we) begin
            ctrl_ff[ctrl_addr] <= data_ff[7:0];
         end
         if (svec_we) begin
            svec_ff[SRC_W'(src_ff)] <= svec_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         ofs_ff <= req_reg_offset;
         data_ff <= req_write_data;
         src_ff <= req_source_id;
         vec_ff <= req_source_vector;
         cpu_ff <= req_cpu_level;
      end
      if (commit) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_take_ff <= rsp_take_in;
         rsp_vector_ff <= rsp_vector_in;
         rsp_level_ff <= rsp_level_in;
         rsp_source_ff <= rsp_source_in;
         rsp_bad_ff <= rsp_bad_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_take_interrupt = rsp_take_ff;
   assign rsp_taken_vector = rsp_vector_ff;
   assign rsp_new_level = rsp_level_ff;
   assign rsp_taken_source = rsp_source_ff;
   assign rsp_bad_access = rsp_bad_ff;

endmodule

`default_nettype wire

// ===== rtl/pic_checker.sv =====
`default_nettype none

module pic_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_read_data,
   input wire logic        rsp_take_interrupt,
   input wire logic [7:0]  rsp_taken_vector,
   input wire logic [2:0]  rsp_new_level,
   input wire logic [4:0]  rsp_taken_source,
   input wire logic        rsp_bad_access
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_take_interrupt) |->
      (rsp_taken_vector == 8'd0 && rsp_new_level == 3'd0 && rsp_taken_source == 5'd0))
      else $error("entry fields set without an interrupt");

   a_entry_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_take_interrupt) |->
      (!rsp_bad_access && rsp_read_data == 32'd0 && rsp_new_level != 3'd0))
      else $error("interrupt entry mixed with register access");

endmodule

bind prioritized_interrupt_controller_core pic_checker u_pic_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_read_data     (rsp_read_data),
   .rsp_take_interrupt(rsp_take_interrupt),
   .rsp_taken_vector  (rsp_taken_vector),
   .rsp_new_level     (rsp_new_level),
   .rsp_taken_source  (rsp_taken_source),
   .rsp_bad_access    (rsp_bad_access)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SRC_COUNT = 32;
   localparam int RANDOM_REQUESTS = 1100;
   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST = 3'd7;

   typedef struct {
      logic [2:0]  action;
      logic [7:0]  offset;
      logic [31:0] data;
      logic [4:0]  source;
      logic [7:0]  vector;
      logic [2:0]  cpu_level;
      bit          drain;
   } bus_request_type;

   typedef struct {
      logic [31:0] read_data;
      logic        take;
      logic [7:0]  vector;
      logic [2:0]  level;
      logic [4:0]  source;
      logic        bad;
   } ctrl_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_reg_offset = '0;
   logic [31:0] req_write_data = '0;
   logic [4:0]  req_source_id = '0;
   logic [7:0]  req_source_vector = '0;
   logic [2:0]  req_cpu_level = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_take_interrupt;
   logic [7:0]  rsp_taken_vector;
   logic [2:0]  rsp_new_level;
   logic [4:0]  rsp_taken_source;
   logic        rsp_bad_access;

   // Shadow copy of the controller state.
   logic [31:0] pend_word;
   logic [31:0] mask_word;
   logic [7:0]  ctrl_byte [SRC_COUNT];
   logic [7:0]  stored_vec [SRC_COUNT];

   bus_request_type   queued_requests [$];
   ctrl_response_type awaited_responses [$];
   bus_request_type   active_req;
   ctrl_response_type oldest;
   logic              drive_valid;
   int unsigned       send_gap = 0;
   int unsigned       send_mode = 0;
   int unsigned       recv_wait = 0;
   int unsigned       recv_mode = 0;
   int unsigned       fail_count = 0;

   prioritized_interrupt_controller_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_reg_offset(req_reg_offset),
      .req_write_data(req_write_data),
      .req_source_id(req_source_id),
      .req_source_vector(req_source_vector),
      .req_cpu_level(req_cpu_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_take_interrupt(rsp_take_interrupt),
      .rsp_taken_vector(rsp_taken_vector),
      .rsp_new_level(rsp_new_level),
      .rsp_taken_source(rsp_taken_source),
      .rsp_bad_access(rsp_bad_access)
   );

   function automatic bus_request_type make_request(input logic [2:0] act,
                                                    input logic [7:0] ofs,
                                                    input logic [31:0] data,
                                                    input logic [4:0] src,
                                                    input logic [7:0] vec,
                                                    input logic [2:0] cpu);
      bus_request_type r;
      r.action = act;
      r.offset = ofs;
      r.data = data;
      r.source = src;
      r.vector = vec;
      r.cpu_level = cpu;
      r.drain = 1'b0;
      return r;
   endfunction

   // Each side keeps an idling style for a while: none, heavy or occasional.
   function automatic int unsigned draw_gap(inout int unsigned mode);
      if ($urandom_range(0, 49) == 0) begin
         mode = $urandom_range(0, 2);
      end
      if (mode == 0) begin
         return 0;
      end else if (mode == 1) begin
         return $urandom_range(0, 19);
      end
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
   endfunction

   function automatic ctrl_response_type predict_response(input bus_request_type r);
      ctrl_response_type e;
      logic [31:0] src_bit;
      logic [2:0]  best_level;
      logic [2:0]  lvl;
      logic [1:0]  best_prio;
      logic [1:0]  pri;
      logic [7:0]  best_vec;
      int          best;
      bit          ctrl_hit;
      e = '{read_data: '0, take: 1'b0, vector: '0, level: '0, source: '0, bad: 1'b0};
      src_bit = 32'd1 << r.source;
      ctrl_hit = (r.offset <= pic_pkg::LAST_CTRL_OFS) && (int'(r.offset) + 1 < SRC_COUNT);
      case (r.action)
         pic_pkg::ACT_TICK: begin
            best = -1;
            best_level = '0;
            best_prio = '0;
            best_vec = pic_pkg::SPURIOUS_VECTOR;
            if ((pend_word & ~mask_word) != 0 &&
                r.cpu_level != pic_pkg::CPU_LEVEL_MAX) begin
               for (int i = 0; i < SRC_COUNT; i++) begin
                  if (pend_word[i] && !mask_word[i]) begin
                     lvl = ctrl_byte[i][4:2];
                     pri = ctrl_byte[i][1:0];
                     if (lvl > best_level || (lvl == best_level && pri > best_prio)) begin
                        best_level = lvl;
                        best_prio = pri;
                        best = i;
                        if ((ctrl_byte[i] & pic_pkg::AUTO_FLAG) != 0) begin
                           best_vec = pic_pkg::AUTOVECTOR_BASE - 8'd1 + 8'(lvl);
                        end else begin
                           best_vec = stored_vec[i];
                        end
                     end
                  end
               end
               if (best >= 0 && best_level > r.cpu_level) begin
                  pend_word[best] = 1'b0;
                  e.take = 1'b1;
                  e.vector = best_vec;
                  e.level = best_level;
                  e.source = 5'(best);
               end
            end
         end
         pic_pkg::ACT_READ: begin
            if (r.offset == pic_pkg::OFS_MASK) begin
               e.read_data = mask_word;
            end else if (r.offset == pic_pkg::OFS_PEND) begin
               e.read_data = pend_word;
            end else if (ctrl_hit) begin
               e.read_data = {24'd0, ctrl_byte[5'(r.offset + 8'd1)]};
            end else begin
               e.bad = 1'b1;
            end
         end
         pic_pkg::ACT_WRITE: begin
            if (r.offset == pic_pkg::OFS_MASK) begin
               mask_word = r.data;
            end else if (r.offset == pic_pkg::OFS_PEND) begin
               e.bad = 1'b0;
            end else if (ctrl_hit) begin
               ctrl_byte[5'(r.offset + 8'd1)] = r.data[7:0];
            end else begin
               e.bad = 1'b1;
            end
         end
         pic_pkg::ACT_ASSERT: begin
            if (int'(r.source) < SRC_COUNT && (pend_word & src_bit) == 0) begin
               pend_word = pend_word | src_bit;
               if ((mask_word & src_bit) == 0) begin
                  stored_vec[r.source] = r.vector;
               end
            end
         end
         pic_pkg::ACT_CLEAR: begin
            if (int'(r.source) < SRC_COUNT && (pend_word & src_bit) != 0) begin
               pend_word = pend_word & ~src_bit;
               stored_vec[r.source] = pic_pkg::SPURIOUS_VECTOR;
            end
         end
         default: begin
            e.bad = 1'b0;
         end
      endcase
      return e;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         drive_valid = req_valid;
         if (req_valid && !req_stall) begin
            awaited_responses.push_back(predict_response(active_req));
            drive_valid = 1'b0;
         end
         if (!drive_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (queued_requests.size() != 0 &&
                         !(queued_requests[0].drain && awaited_responses.size() != 0)) begin
               active_req = queued_requests.pop_front();
               req_action <= active_req.action;
               req_reg_offset <= active_req.offset;
               req_write_data <= active_req.data;
               req_source_id <= active_req.source;
               req_source_vector <= active_req.vector;
               req_cpu_level <= active_req.cpu_level;
               drive_valid = 1'b1;
               send_gap = draw_gap(send_mode);
            end
         end
         req_valid <= drive_valid;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response arrived with no request outstanding");
               fail_count++;
            end else begin
               oldest = awaited_responses.pop_front();
               if (rsp_read_data !== oldest.read_data) begin
                  $error("read_data: expected %0h, actual %0h", oldest.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_take_interrupt !== oldest.take) begin
                  $error("take_interrupt: expected %0h, actual %0h", oldest.take,
                         rsp_take_interrupt);
                  fail_count++;
               end
               if (rsp_taken_vector !== oldest.vector) begin
                  $error("taken_vector: expected %0h, actual %0h", oldest.vector,
                         rsp_taken_vector);
                  fail_count++;
               end
               if (rsp_new_level !== oldest.level) begin
                  $error("new_level: expected %0h, actual %0h", oldest.level, rsp_new_level);
                  fail_count++;
               end
               if (rsp_taken_source !== oldest.source) begin
                  $error("taken_source: expected %0h, actual %0h", oldest.source,
                         rsp_taken_source);
                  fail_count++;
               end
               if (rsp_bad_access !== oldest.bad) begin
                  $error("bad_access: expected %0h, actual %0h", oldest.bad, rsp_bad_access);
                  fail_count++;
               end
            end
            recv_wait = draw_gap(recv_mode);
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0);
      end
   end

   initial begin
      bus_request_type req;
      logic [2:0]      act;
      logic [7:0]      ofs;
      logic [31:0]     data;
      logic [4:0]      src;
      logic [2:0]      cpu;
      int unsigned     pick;

      pend_word = '0;
      mask_word = '1;
      for (int i = 0; i < SRC_COUNT; i++) begin
         ctrl_byte[i] = '0;
         stored_vec[i] = pic_pkg::SPURIOUS_VECTOR;
      end
      for (int i = 1; i <= 7; i++) begin
         ctrl_byte[i] = 8'(4 * i);
      end
      ctrl_byte[8] = 8'd32;
      for (int i = 9; i <= 11; i++) begin
         ctrl_byte[i] = pic_pkg::AUTO_FLAG;
      end

      // Reset contents, uncovered offsets and the read-only pending word.
      queued_requests.push_back(make_request(pic_pkg::ACT_READ, pic_pkg::OFS_MASK,
                                             '0, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_READ, pic_pkg::OFS_PEND,
                                             '0, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_READ, 8'd0, '0, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_READ, pic_pkg::LAST_CTRL_OFS,
                                             '0, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_READ, 8'd13, '0, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_READ, 8'hFF, '1, '1, '1, '1));
      queued_requests.push_back(make_request(pic_pkg::ACT_WRITE, pic_pkg::OFS_PEND,
                                             '1, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_WRITE, 8'hFF, '1, '0, '0, '0));
      // A masked source gets its pending bit but keeps the spurious vector.
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd9, 8'h77, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0, 3'd0));
      queued_requests.push_back(make_request(pic_pkg::ACT_WRITE, pic_pkg::OFS_MASK,
                                             32'h0, '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0, 3'd0));
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd5, 8'hA5, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd5, 8'h11, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0,
                                             pic_pkg::CPU_LEVEL_MAX));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0, 3'd5));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0, 3'd4));
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd31, 8'hFF, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_CLEAR, '0, '0, 5'd31, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_CLEAR, '0, '0, 5'd31, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_WRITE, 8'd7, 32'hFFFF_FF9F,
                                             '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd8, 8'h00, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0, 3'd0));
      queued_requests.push_back(make_request(ACT_UNUSED_LAST, '1, '1, '1, '1, '1));
      // Equal level and priority on sources 2 and 3: the lower index must win.
      queued_requests.push_back(make_request(pic_pkg::ACT_WRITE, 8'd2, 32'h0000_0008,
                                             '0, '0, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd3, 8'h33, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_ASSERT, '0, '0, 5'd2, 8'h22, '0));
      queued_requests.push_back(make_request(pic_pkg::ACT_TICK, '0, '0, '0, '0, 3'd0));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) begin
            ofs = 8'($urandom_range(0, pic_pkg::LAST_CTRL_OFS));
         end else if (pick < 13) begin
            ofs = pic_pkg::OFS_MASK;
         end else if (pick < 15) begin
            ofs = pic_pkg::OFS_PEND;
         end else begin
            ofs = 8'($urandom);
         end
         src = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 13)) : 5'($urandom);
         cpu = ($urandom_range(0, 2) != 0) ? 3'($urandom_range(0, 3)) : 3'($urandom);
         data = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            act = pic_pkg::ACT_TICK;
         end else if (pick < 55) begin
            act = pic_pkg::ACT_ASSERT;
         end else if (pick < 65) begin
            act = pic_pkg::ACT_CLEAR;
         end else if (pick < 82) begin
            act = pic_pkg::ACT_WRITE;
         end else if (pick < 97) begin
            act = pic_pkg::ACT_READ;
         end else begin
            act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
         end
         if (act == pic_pkg::ACT_WRITE && ofs == pic_pkg::OFS_MASK) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               data = $urandom & $urandom & $urandom;
            end else if (pick == 6) begin
               data = '0;
            end else if (pick == 7) begin
               data = '1;
            end
         end
         req = make_request(act, ofs, data, src, 8'($urandom), cpu);
         req.drain = (n % 250 == 100);
         queued_requests.push_back(req);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== prioritized_interrupt_controller_core.f =====
rtl/pic_pkg.sv
rtl/pic_scan.sv
rtl/prioritized_interrupt_controller_core.sv
rtl/pic_checker.sv
tb/sv/tb_top.sv
